// ===== rtl/core/dte_pkg.sv =====
// ----------------------------------------------------------------------------
// dte_pkg
// Shared widths, constants, types and the sine table helper for the DDS tone
// source with a linear envelope.
// ----------------------------------------------------------------------------
package dte_pkg;

  // Field and datapath widths.
  localparam int PHASE_W = 32;
  localparam int FREQ_W  = 15;
  localparam int CODE_W  = 12;
  localparam int MAG_W   = 11;
  localparam int LEVEL_W = 9;

  // Envelope and converter constants.
  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 9'd256;
  localparam logic [LEVEL_W-1:0] LEVEL_STEP  = 9'd4;
  localparam int                 LEVEL_SHIFT = 8;
  localparam logic [CODE_W-1:0]  MIDSCALE    = 12'd2048;
  localparam logic [63:0]        PEAK        = 64'd2047;
  localparam logic [63:0]        HALF_PI_Q31 = 64'd3373259426;

  // Operation codes of an input item.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_TONE = 1'b1;

  // Output queue sizing.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  // Series divisors for the sine and cosine expansions, terms one to twelve.
  localparam int unsigned TRIG_TERMS = 12;
  localparam logic [63:0] SIN_DIV [TRIG_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };
  localparam logic [63:0] COS_DIV [TRIG_TERMS] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  // Phase increment update from the step unit to the tone core.
  typedef struct packed {
    logic               busy;
    logic               wr;
    logic [PHASE_W-1:0] step;
  } step_upd_t;

  // Sine or cosine of a Q31 angle in [0, pi/4], Q31 result. Only used while
  // the sine table is built at elaboration.
  function automatic logic [63:0] trig_q31(input logic [63:0] ang, input logic want_cos);
    logic [63:0]        a2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    a2   = (ang * ang) >> 31;
    term = want_cos ? 64'h8000_0000 : ang;
    sum  = signed'(term);
    for (int k = 0; k < TRIG_TERMS; k++) begin
      if (want_cos) begin
        term = ((term * a2) >> 31) / COS_DIV[k];
      end else begin
        term = ((term * a2) >> 31) / SIN_DIV[k];
      end
      // Terms alternate in sign, starting with a subtraction.
      if ((k & 1) == 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    return unsigned'(sum);
  endfunction

endpackage

// ===== rtl/core/dds_tone_with_envelope.sv =====
// ----------------------------------------------------------------------------
// dds_tone_with_envelope
// DDS sine tone source with a linear attack and release envelope. A tick item
// (op 0) yields one 12-bit converter sample, 2048 meaning silence; a set-tone
// item (op 1) loads the phase increment for a frequency in hertz and opens the
// gate, and frequency zero releases the note. Ticks are taken one per clock
// while the input is not stalled, and each sample passes the table read
// register, the scaling register and a four-entry output queue, so ticks keep
// flowing while a sample waits to be taken. A nonzero set-tone item stalls
// the input while the pipelined increment divider is busy; a release does not
// stall it. The sine table has WAVE_ENTRIES entries, built at elaboration, and
// is read through a registered port at the top bits of the phase.
// ----------------------------------------------------------------------------
module dds_tone_with_envelope
  import dte_pkg::*;
#(
  parameter int SAMPLE_RATE  = 16000,
  parameter int WAVE_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [FREQ_W-1:0] tone_freq,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] dac_code
);

  localparam int IDX_W = $clog2(WAVE_ENTRIES);
  localparam int PRD_W = PHASE_W + IDX_W;

  typedef logic signed [CODE_W-1:0] wave_t [WAVE_ENTRIES];

  // One sine table entry: trunc(2047 * sin(2*pi*i/WAVE_ENTRIES)).
  function automatic logic signed [CODE_W-1:0] rom_value(input int unsigned i);
    logic [63:0] four_i;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] ang;
    logic [63:0] mag;
    logic        use_cos;
    four_i  = 64'(i) << 2;
    quad    = four_i / WAVE_ENTRIES;
    rem     = four_i - quad * WAVE_ENTRIES;
    use_cos = quad[0];
    // Fold the angle onto at most pi/4 with the complementary function.
    if ((rem << 1) > WAVE_ENTRIES) begin
      rem     = WAVE_ENTRIES - rem;
      use_cos = !use_cos;
    end
    ang = HALF_PI_Q31 * rem / WAVE_ENTRIES;
    mag = (trig_q31(ang, use_cos) * PEAK) >> 31;
    if (mag > PEAK) begin
      mag = PEAK;
    end
    if (quad >= 2) begin
      return CODE_W'(-mag);
    end
    return CODE_W'(mag);
  endfunction

  function automatic wave_t build_wave();
    wave_t w;
    for (int i = 0; i < WAVE_ENTRIES; i++) begin
      w[i] = rom_value(i);
    end
    return w;
  endfunction

  localparam wave_t WAVE_INIT = build_wave();

  // Tone state.
  logic [PHASE_W-1:0]   phase;
  logic [PHASE_W-1:0]   phase_step;
  logic [LEVEL_W-1:0]   level;
  logic [LEVEL_W-1:0]   level_next;
  logic                 gate_on;

  // Handshake and pipeline control.
  logic                 in_xfer;
  logic                 tick_xfer;
  logic                 tone_xfer;
  logic                 out_xfer;
  logic                 s1_valid;
  logic                 s2_valid;
  logic [OUT_CNT_W-1:0] credits;
  logic [OUT_CNT_W-1:0] fifo_cnt;
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  step_upd_t            step;

  // Sample datapath.
  logic [PRD_W-1:0]         idx_prod;
  logic [IDX_W-1:0]         rom_idx;
  logic signed [CODE_W-1:0] rom_q;
  logic [LEVEL_W-1:0]       s1_level;
  logic [MAG_W-1:0]         s1_mag;
  logic [MAG_W+LEVEL_W-1:0] scale_prod;
  logic [MAG_W-1:0]         s2_mag;
  logic                     s2_neg;
  logic [CODE_W-1:0]        code;
  logic [CODE_W-1:0]        fifo_mem [OUT_DEPTH];

  assign in_xfer   = in_valid && !in_stall;
  assign tick_xfer = in_xfer && (op == OP_TICK);
  assign tone_xfer = in_xfer && (op == OP_TONE);
  assign out_xfer  = out_valid && !out_stall;
  assign in_stall  = step.busy || (credits == OUT_CNT_W'(OUT_DEPTH));
  assign out_valid = (fifo_cnt != '0);
  assign dac_code  = fifo_mem[rd_ptr];

  // Increment divider.
  dte_step_calc #(
    .SAMPLE_RATE(SAMPLE_RATE)
  ) u_step (
    .clk   (clk),
    .rst   (rst),
    .start (tone_xfer && (tone_freq != '0)),
    .freq  (tone_freq),
    .upd   (step)
  );

  // Envelope moves one step toward full scale or zero; levels stay multiples
  // of the step, so no clamp is needed.
  always_comb begin
    if (gate_on) begin
      level_next = (level == LEVEL_FULL) ? level : level + LEVEL_STEP;
    end else begin
      level_next = (level == '0) ? level : level - LEVEL_STEP;
    end
  end

  // Table index from the top of the phase.
  always_comb begin
    idx_prod = PRD_W'(phase) * PRD_W'(WAVE_ENTRIES);
    rom_idx  = idx_prod[PHASE_W +: IDX_W];
  end

  // Phase, increment, envelope and gate updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      phase_step <= '0;
      level      <= '0;
      gate_on    <= 1'b0;
    end else begin
      if (step.wr) begin
        phase_step <= step.step;
      end
      if (tone_xfer) begin
        if (tone_freq == '0) begin
          gate_on <= 1'b0;
        end else begin
          gate_on <= 1'b1;
          if (level == '0) begin
            phase <= '0;
          end
        end
      end
      if (tick_xfer) begin
        level <= level_next;
        if (level_next != '0) begin
          phase <= phase + phase_step;
        end
      end
    end
  end

  // Sample pipeline valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= tick_xfer;
      s2_valid <= s1_valid;
    end
  end

  // Registered table read.
  always_ff @(posedge clk) begin
    if (tick_xfer) begin
      rom_q    <= WAVE_INIT[rom_idx];
      s1_level <= level_next;
    end
  end

  // Scale the magnitude by level/256, truncating toward zero.
  always_comb begin
    s1_mag     = rom_q[CODE_W-1] ? MAG_W'(-rom_q) : rom_q[MAG_W-1:0];
    scale_prod = (MAG_W+LEVEL_W)'(s1_mag) * (MAG_W+LEVEL_W)'(s1_level);
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_mag <= scale_prod[LEVEL_SHIFT +: MAG_W];
      s2_neg <= rom_q[CODE_W-1];
    end
  end

  // Offset to the unsigned converter range.
  always_comb begin
    if (s2_neg) begin
      code = MIDSCALE - CODE_W'(s2_mag);
    end else begin
      code = MIDSCALE + CODE_W'(s2_mag);
    end
  end

  // Output queue storage.
  always_ff @(posedge clk) begin
    if (s2_valid) begin
      fifo_mem[wr_ptr] <= code;
    end
  end

  // Queue pointers, fill count and credits for ticks in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      credits  <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_cnt <= fifo_cnt + OUT_CNT_W'(s2_valid) - OUT_CNT_W'(out_xfer);
      credits  <= credits + OUT_CNT_W'(tick_xfer) - OUT_CNT_W'(out_xfer);
    end
  end

  // Envelope level stays on the step grid within full scale.
  assert property (@(posedge clk) disable iff (rst)
    (level <= LEVEL_FULL) && (level[1:0] == 2'b00))
    else $error("envelope level off grid or above full scale");

  // Queued samples never exceed the ticks that reserved space.
  assert property (@(posedge clk) disable iff (rst)
    (credits <= OUT_CNT_W'(OUT_DEPTH)) && (fifo_cnt <= credits))
    else $error("output queue count exceeds reserved credits");

  // A silent tick with the gate closed leaves the phase alone.
  assert property (@(posedge clk) disable iff (rst)
    (tick_xfer && !gate_on && (level == '0)) |=> $stable(phase))
    else $error("phase advanced during silence");

  // A finished sample is never the zero code.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dac_code != '0))
    else $error("sample out of converter range");

endmodule

// ===== rtl/core/dte_step_calc.sv =====
// ----------------------------------------------------------------------------
// dte_step_calc
// Pipelined phase increment unit: floor(freq * 2^32 / SAMPLE_RATE) kept to
// 32 bits, built from a quotient and remainder split plus a reciprocal
// multiply with one correction step.
// ----------------------------------------------------------------------------
module dte_step_calc
  import dte_pkg::*;
#(
  parameter int SAMPLE_RATE = 16000
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FREQ_W-1:0] freq,
  output step_upd_t         upd
);

  localparam int RATE_W = $clog2(SAMPLE_RATE + 1);
  localparam int Y_W    = FREQ_W + RATE_W;
  localparam int M_W    = 34 - $clog2(SAMPLE_RATE);
  localparam int P_W    = Y_W + M_W;

  localparam logic [63:0]        TWO_32  = 64'd1 << 32;
  localparam logic [PHASE_W-1:0] STEP_Q  = PHASE_W'(TWO_32 / SAMPLE_RATE);
  localparam logic [RATE_W-1:0]  STEP_RM = RATE_W'(TWO_32 % SAMPLE_RATE);
  localparam logic [M_W-1:0]     RECIP_M = M_W'((TWO_32 << 1) / SAMPLE_RATE);
  localparam logic [RATE_W-1:0]  RATE_C  = RATE_W'(SAMPLE_RATE);

  logic                 v1, v2, v3;
  logic [PHASE_W-1:0]   s1_fq, s2_fq, s3_fq;
  logic [Y_W-1:0]       s1_y, s2_y;
  logic [FREQ_W-1:0]    s2_qe, s3_qe;
  logic [RATE_W:0]      s3_rem;
  logic [P_W-1:0]       recip_prod;
  logic [Y_W-1:0]       qe_times_rate;
  logic [Y_W-1:0]       rem_full;
  logic [FREQ_W-1:0]    q_fix;

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Reciprocal estimate of the remainder part and its correction residue.
  always_comb begin
    recip_prod    = P_W'(s1_y) * P_W'(RECIP_M);
    qe_times_rate = Y_W'(s2_qe) * Y_W'(RATE_C);
    rem_full      = s2_y - qe_times_rate;
  end

  // Stage 1 splits the product into the whole-quotient and remainder terms,
  // stage 2 estimates the remainder quotient, stage 3 forms the residue.
  always_ff @(posedge clk) begin
    if (start) begin
      s1_fq <= PHASE_W'(PHASE_W'(freq) * STEP_Q);
      s1_y  <= Y_W'(freq) * Y_W'(STEP_RM);
    end
    if (v1) begin
      s2_fq <= s1_fq;
      s2_y  <= s1_y;
      s2_qe <= recip_prod[33 +: FREQ_W];
    end
    if (v2) begin
      s3_fq  <= s2_fq;
      s3_qe  <= s2_qe;
      s3_rem <= rem_full[RATE_W:0];
    end
  end

  // The estimate is low by at most one.
  always_comb begin
    q_fix    = s3_qe + FREQ_W'(s3_rem >= {1'b0, RATE_C});
    upd.busy = v1 | v2 | v3;
    upd.wr   = v3;
    upd.step = s3_fq + PHASE_W'(q_fix);
  end

endmodule
